// ===== design/ogru_pkg.sv =====
`default_nettype none
package ogru_pkg;

  typedef logic signed [15:0] pos_t;
  typedef logic [15:0] angle_t;
  typedef logic [11:0] range_t;
  typedef logic [3:0] cell_idx_t;
  typedef logic [1:0] mark_t;
  typedef logic [3:0] mask_t;
  typedef logic signed [15:0] trig_t;

  localparam mark_t MARK_UNKNOWN = 2'd0;
  localparam mark_t MARK_EMPTY = 2'd1;
  localparam mark_t MARK_WALL = 2'd2;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam angle_t QUARTER_TURN = 16'd16384;
  localparam angle_t THREE_QUARTER_TURN = 16'd49152;

  localparam int RANGE_DIV = 5;
  localparam int FRAC_W = 15;
  localparam int PROD_W = 29;
  localparam int ACC_W = 20;
  localparam int MAG_W = 18;

  localparam logic [14:0] SINE_QUARTER [65] = '{
    15'd0, 15'd804, 15'd1608, 15'd2410, 15'd3212, 15'd4011, 15'd4808, 15'd5602,
    15'd6393, 15'd7179, 15'd7962, 15'd8739, 15'd9512, 15'd10278, 15'd11039, 15'd11793,
    15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846,
    15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403,
    15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329,
    15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683, 15'd28105, 15'd28510,
    15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273, 15'd30571, 15'd30852,
    15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971, 15'd32137, 15'd32285,
    15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757, 15'd32767
  };

  function automatic trig_t sine_q15(input angle_t angle);
    logic [1:0] quad;
    logic [5:0] k;
    logic [6:0] kk;
    trig_t v;
    quad = angle[15:14];
    k = angle[13:8];
    kk = quad[0] ? (7'd64 - {1'b0, k}) : {1'b0, k};
    v = trig_t'({1'b0, SINE_QUARTER[kk]});
    return quad[1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ===== design/ogru_ifs.sv =====
`default_nettype none
interface ogru_in_if;
  import ogru_pkg::*;
  logic valid;
  logic ready;
  logic action;
  pos_t pos_x;
  pos_t pos_y;
  angle_t heading;
  range_t front_range;
  range_t left_range;
  range_t right_range;
  cell_idx_t read_col;
  cell_idx_t read_row;

  modport source (
    output valid, action, pos_x, pos_y, heading, front_range, left_range,
    right_range, read_col, read_row,
    input ready
  );
  modport sink (
    input valid, action, pos_x, pos_y, heading, front_range, left_range,
    right_range, read_col, read_row,
    output ready
  );
endinterface

interface ogru_out_if;
  import ogru_pkg::*;
  logic valid;
  logic ready;
  mark_t cell_mark;
  mask_t write_mask;

  modport source (output valid, cell_mark, write_mask, input ready);
  modport sink (input valid, cell_mark, write_mask, output ready);
endinterface
`default_nettype wire

// ===== design/occupancy_grid_range_update.sv =====
`default_nettype none
// Channel   Direction  Payload
// in_chan   request    action, pos_x, pos_y, heading, ranges, read_col, read_row
// out_chan  result     cell_mark, write_mask
// cfg_*     write      mapping_enabled
//
// An enabled sensor update covers four points, each with an x and a y coordinate; each of the
// eight coordinates runs a product, a sign fold, a reciprocal multiply and a range check
// through one shared multiplier. A disabled update goes straight to its result; a read passes
// through an address and a data state. After reset a clearing pass writes all GRID_COLS * GRID_ROWS
// cells with unknown marks before the first request. One request is in flight at a time; a result
// held by the output register stalls only the delivery of the next one.
module occupancy_grid_range_update #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 16,
  parameter int CELL_SIZE = 50
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  ogru_in_if.sink    in_chan,
  ogru_out_if.source out_chan
);
  import ogru_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int DIVISOR = RANGE_DIV * CELL_SIZE;
  localparam int MUL_W = MAG_W + 2;
  localparam int RECIP_SH = MAG_W + $clog2(DIVISOR);
  localparam longint RECIP = ((longint'(1) << RECIP_SH) + longint'(DIVISOR - 1)) /
                             longint'(DIVISOR);
  localparam logic signed [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_PREP, S_DIV, S_IDX, S_WRITE, S_RD_ADDR, S_RD_DATA, S_DONE
  } state_t;

  state_t state_r;
  logic cfg_en_r;
  logic [ADDR_W-1:0] clr_addr_r;
  pos_t pos_x_r, pos_y_r;
  angle_t head_r;
  range_t front_r, left_r, right_r;
  logic [1:0] pt_r;
  logic axis_r;
  logic signed [PROD_W-1:0] prod_r;
  logic neg_r;
  logic [MAG_W-1:0] mq_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic okx_r, oky_r;
  mark_t mark_r;
  mask_t mask_r;
  logic out_valid_r;
  mark_t out_mark_r;
  mask_t out_mask_r;

  angle_t angle_c;
  range_t range_c;
  trig_t trig_c;
  logic signed [MUL_W-1:0] mul_a_c, mul_b_c;
  logic signed [2*MUL_W-1:0] mul_c;
  logic signed [ACC_W-1:0] pos_ext_c, acc_c, mag_src_c;
  logic frac_zero_c;
  logic in_grid_c;
  logic [ADDR_W-1:0] addr_c;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  mark_t ram_wdata, ram_rdata;
  logic in_acc;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.cell_mark = out_mark_r;
  assign out_chan.write_mask = out_mask_r;

  always_comb begin
    case (pt_r)
      2'd0: begin
        range_c = '0;
        angle_c = head_r;
      end
      2'd1: begin
        range_c = front_r;
        angle_c = head_r;
      end
      2'd2: begin
        range_c = left_r;
        angle_c = head_r + QUARTER_TURN;
      end
      default: begin
        range_c = right_r;
        angle_c = head_r + THREE_QUARTER_TURN;
      end
    endcase
    trig_c = sine_q15(axis_r ? angle_c : angle_c + QUARTER_TURN);
    if (state_r == S_DIV) begin
      mul_a_c = MUL_W'(mq_r);
      mul_b_c = RECIP_C;
    end else begin
      mul_a_c = MUL_W'($signed({1'b0, range_c}));
      mul_b_c = MUL_W'(trig_c);
    end
    mul_c = mul_a_c * mul_b_c;
    pos_ext_c = ACC_W'(axis_r ? pos_y_r : pos_x_r);
    acc_c = (pos_ext_c <<< 2) + pos_ext_c + ACC_W'(prod_r >>> FRAC_W);
    frac_zero_c = (prod_r[FRAC_W-1:0] == '0);
    mag_src_c = acc_c[ACC_W-1] ? (~acc_c + ACC_W'(frac_zero_c)) : acc_c;
    if (neg_r) begin
      in_grid_c = (mq_r == '0);
    end else if (axis_r) begin
      in_grid_c = (mq_r < MAG_W'(GRID_ROWS));
    end else begin
      in_grid_c = (mq_r < MAG_W'(GRID_COLS));
    end
    addr_c = ADDR_W'(ADDR_W'(col_r) * ADDR_W'(GRID_ROWS)) + ADDR_W'(row_r);
    if (state_r == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = MARK_UNKNOWN;
    end else begin
      ram_we = (state_r == S_WRITE) && okx_r && oky_r;
      ram_waddr = addr_c;
      ram_wdata = (pt_r == 2'd0) ? MARK_EMPTY : MARK_WALL;
    end
  end

  ogru_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_c),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cfg_en_r <= 1'b0;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
      pt_r <= '0;
      axis_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_en_r <= cfg_wr_data;
      end
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            pos_x_r <= in_chan.pos_x;
            pos_y_r <= in_chan.pos_y;
            head_r <= in_chan.heading;
            front_r <= in_chan.front_range;
            left_r <= in_chan.left_range;
            right_r <= in_chan.right_range;
            col_r <= COL_W'(in_chan.read_col);
            row_r <= ROW_W'(in_chan.read_row);
            okx_r <= ({5'd0, in_chan.read_col} < 9'(GRID_COLS));
            oky_r <= ({5'd0, in_chan.read_row} < 9'(GRID_ROWS));
            pt_r <= '0;
            axis_r <= 1'b0;
            mark_r <= MARK_UNKNOWN;
            mask_r <= '0;
            if (in_chan.action == ACT_READ) begin
              state_r <= S_RD_ADDR;
            end else if (cfg_en_r) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          prod_r <= PROD_W'(mul_c);
          state_r <= S_PREP;
        end
        S_PREP: begin
          neg_r <= acc_c[ACC_W-1];
          mq_r <= mag_src_c[MAG_W-1:0];
          state_r <= S_DIV;
        end
        S_DIV: begin
          mq_r <= MAG_W'(mul_c >>> RECIP_SH);
          state_r <= S_IDX;
        end
        S_IDX: begin
          if (axis_r) begin
            row_r <= mq_r[ROW_W-1:0];
            oky_r <= in_grid_c;
            axis_r <= 1'b0;
            state_r <= S_WRITE;
          end else begin
            col_r <= mq_r[COL_W-1:0];
            okx_r <= in_grid_c;
            axis_r <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_WRITE: begin
          if (okx_r && oky_r) begin
            mask_r[pt_r] <= 1'b1;
          end
          pt_r <= pt_r + 1'b1;
          state_r <= (pt_r == 2'd3) ? S_DONE : S_MUL;
        end
        S_RD_ADDR: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          mark_r <= (okx_r && oky_r) ? ram_rdata : MARK_UNKNOWN;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_mark_r <= mark_r;
            out_mask_r <= mask_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_writes_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (ram_we && ram_wdata == MARK_UNKNOWN))
    else $error("clearing pass must write unknown marks");

  a_update_write_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |-> cfg_en_r)
    else $error("grid written while mapping is disabled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("second request accepted while one is in flight");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mark_r == MARK_UNKNOWN || out_mask_r == '0))
    else $error("result carries both a mark and a write mask");
`endif

endmodule
`default_nettype wire

// ===== design/ogru_ram.sv =====
`default_nettype none
module ogru_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
